[hdl/epoch_to_calendar_fields_defines.svh]
// Assertion helpers for the module that checks itself.
`ifndef EPOCH_TO_CALENDAR_FIELDS_DEFINES_SVH
`define EPOCH_TO_CALENDAR_FIELDS_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ECF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ECF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/ecf_pkg.sv]
`timescale 1ns / 1ps
package ecf_pkg;

   localparam int EPOCH_W      = 32;
   localparam int DAYS_W       = 16;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [31:0] VALID_AFTER_RESET = 32'd1575158400;

   localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
   localparam logic [5:0]  HOURS_PER_DAY  = 6'd24;
   localparam logic [3:0]  DAYS_PER_WEEK  = 4'd7;
   localparam logic [3:0]  THURSDAY_SHIFT = 4'd4;

   // reciprocals: x / 60 = (x * RECIP_60) >> 37 and x / 24 = (x * RECIP_24) >> 36 for any
   // 32-bit x; x / 7 = (x * RECIP_7) >> 19 for any x below 2**16
   localparam logic [31:0] RECIP_60 = 32'h8888_8889;
   localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;
   localparam logic [31:0] RECIP_7  = 32'd74899;

   localparam logic [8:0]  DAYS_COMMON_YEAR = 9'd365;
   localparam logic [8:0]  DAYS_LEAP_YEAR   = 9'd366;
   localparam logic [7:0]  YEARS_TO_2000    = 8'd30;

   // 1970 taken modulo 4, 100 and 400
   localparam logic [1:0]  EPOCH_MOD4   = 2'd2;
   localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
   localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
   localparam logic [6:0]  LAST_MOD100  = 7'd99;
   localparam logic [8:0]  LAST_MOD400  = 9'd399;

   localparam logic [3:0]  MONTH_JAN = 4'd0;
   localparam logic [3:0]  MONTH_FEB = 4'd1;
   localparam logic [3:0]  MONTH_DEC = 4'd11;

   // divider pass codes
   localparam logic [1:0]  PASS_SEC  = 2'd0;
   localparam logic [1:0]  PASS_MIN  = 2'd1;
   localparam logic [1:0]  PASS_HOUR = 2'd2;
   localparam logic [1:0]  PASS_DAY  = 2'd3;

   typedef struct packed {
      logic [5:0]        sec;
      logic [5:0]        min;
      logic [4:0]        hour;
      logic [DAYS_W-1:0] days;
      logic [2:0]        wday;
      logic              valid;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } queue_ctl_type;

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10:                  len = 5'd30;
         MONTH_FEB:                                len = leap ? 5'd29 : 5'd28;
         default:                                  len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[hdl/ecf_front.sv]
`timescale 1ns / 1ps
module ecf_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ecf_pkg::EPOCH_W-1:0]  epoch_seconds,
   input  logic [31:0]                  valid_after,
   input  logic                         queue_full,
   output logic                         queue_push,
   output ecf_pkg::entry_type           queue_data
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MUL  = 4'b0010,
      F_SUB  = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type                    state_ff, state_in;
   logic [ecf_pkg::EPOCH_W-1:0]        num_ff, num_in;
   logic [63:0]                        prod_ff, prod_in;
   logic [1:0]                         pass_ff, pass_in;
   logic [2:0]                         mod7_ff, mod7_in;
   logic [5:0]                         sec_ff, sec_in;
   logic [5:0]                         min_ff, min_in;
   logic [4:0]                         hour_ff, hour_in;
   logic                               valid_ff, valid_in;

   logic [31:0] recip;
   logic [5:0]  divisor;
   logic [31:0] quot;
   logic [11:0] quot_lo_mul;
   logic [5:0]  rem_step;
   logic [3:0]  wday_sum;
   logic [3:0]  wday_mod;

   always_comb begin
      // the high product bits give the exact quotient over each pass's input range
      case (pass_ff)
         ecf_pkg::PASS_HOUR: begin
            recip   = ecf_pkg::RECIP_24;
            divisor = ecf_pkg::HOURS_PER_DAY;
            quot    = {4'd0, prod_ff[63:36]};
         end
         ecf_pkg::PASS_DAY: begin
            recip   = ecf_pkg::RECIP_7;
            divisor = {2'b00, ecf_pkg::DAYS_PER_WEEK};
            quot    = prod_ff[50:19];
         end
         default: begin
            recip   = ecf_pkg::RECIP_60;
            divisor = ecf_pkg::SECS_PER_MIN;
            quot    = {5'd0, prod_ff[63:37]};
         end
      endcase
      // the remainder is below 64, so the low six bits carry it exactly
      quot_lo_mul = 12'(quot[5:0]) * 12'(divisor);
      rem_step    = num_ff[5:0] - quot_lo_mul[5:0];
      wday_sum = {1'b0, mod7_ff} + ecf_pkg::THURSDAY_SHIFT;
      wday_mod = (wday_sum >= ecf_pkg::DAYS_PER_WEEK) ? wday_sum - ecf_pkg::DAYS_PER_WEEK
                                                       : wday_sum;
   end

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      prod_in  = prod_ff;
      pass_in  = pass_ff;
      mod7_in  = mod7_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      valid_in = valid_ff;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               num_in   = epoch_seconds;
               pass_in  = ecf_pkg::PASS_SEC;
               valid_in = (epoch_seconds > valid_after);
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            prod_in  = 64'(num_ff) * 64'(recip);
            state_in = F_SUB;
         end
         F_SUB: begin
            num_in   = quot;
            state_in = F_MUL;
            case (pass_ff)
               ecf_pkg::PASS_SEC: begin
                  sec_in  = rem_step;
                  pass_in = ecf_pkg::PASS_MIN;
               end
               ecf_pkg::PASS_MIN: begin
                  min_in  = rem_step;
                  pass_in = ecf_pkg::PASS_HOUR;
               end
               ecf_pkg::PASS_HOUR: begin
                  hour_in = rem_step[4:0];
                  pass_in = ecf_pkg::PASS_DAY;
               end
               default: begin
                  // hold the day count, keep only its remainder by seven
                  num_in   = num_ff;
                  mod7_in  = rem_step[2:0];
                  state_in = F_PUSH;
               end
            endcase
         end
         F_PUSH: begin
            if (!queue_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff   <= num_in;
      prod_ff  <= prod_in;
      pass_ff  <= pass_in;
      mod7_ff  <= mod7_in;
      sec_ff   <= sec_in;
      min_ff   <= min_in;
      hour_ff  <= hour_in;
      valid_ff <= valid_in;
   end

   assign busy       = (state_ff != F_IDLE);
   assign queue_push = (state_ff == F_PUSH) && !queue_full;

   always_comb begin
      queue_data.sec   = sec_ff;
      queue_data.min   = min_ff;
      queue_data.hour  = hour_ff;
      queue_data.days  = num_ff[ecf_pkg::DAYS_W-1:0];
      queue_data.wday  = 3'(wday_mod + 4'd1);
      queue_data.valid = valid_ff;
   end

endmodule

[hdl/ecf_queue.sv]
`timescale 1ns / 1ps
module ecf_queue #(
   parameter int DEPTH = ecf_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ecf_pkg::entry_type     push_data,
   input  logic                   pop,
   output ecf_pkg::entry_type     pop_data,
   output logic                   full,
   output logic                   empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ecf_pkg::entry_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

[hdl/ecf_back.sv]
`timescale 1ns / 1ps
module ecf_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         queue_empty,
   input  ecf_pkg::entry_type           queue_data,
   output logic                         queue_pop,
   output logic                         rsp_valid,
   output logic [5:0]                   rsp_second_of_minute,
   output logic [5:0]                   rsp_minute_of_hour,
   output logic [4:0]                   rsp_hour_of_day,
   output logic [15:0]                  rsp_days_since_epoch,
   output logic [2:0]                   rsp_weekday,
   output logic signed [7:0]            rsp_year_from_2000,
   output logic [8:0]                   rsp_day_in_year,
   output logic [3:0]                   rsp_month_number,
   output logic [4:0]                   rsp_day_in_month,
   output logic                         rsp_time_valid
);

   typedef enum logic [2:0] {
      B_IDLE  = 3'b001,
      B_YEAR  = 3'b010,
      B_MONTH = 3'b100
   } back_state_type;

   back_state_type                  state_ff, state_in;
   ecf_pkg::entry_type              item_ff, item_in;
   logic [ecf_pkg::DAYS_W-1:0]      rem_ff, rem_in;
   logic [7:0]                      year_ff, year_in;
   logic [1:0]                      mod4_ff, mod4_in;
   logic [6:0]                      mod100_ff, mod100_in;
   logic [8:0]                      mod400_ff, mod400_in;
   logic [8:0]                      doy_ff, doy_in;
   logic [3:0]                      month_ff, month_in;
   logic                            out_valid_ff, out_valid_in;
   ecf_pkg::entry_type              out_item_ff, out_item_in;
   logic [7:0]                      out_year_ff, out_year_in;
   logic [8:0]                      out_doy_ff, out_doy_in;
   logic [3:0]                      out_month_ff, out_month_in;
   logic [4:0]                      out_mday_ff, out_mday_in;

   logic       leap;
   logic [8:0] year_len;
   logic [4:0] mon_len;

   always_comb begin
      leap     = (mod4_ff == 2'd0) && ((mod100_ff != 7'd0) || (mod400_ff == 9'd0));
      year_len = leap ? ecf_pkg::DAYS_LEAP_YEAR : ecf_pkg::DAYS_COMMON_YEAR;
      mon_len  = ecf_pkg::month_len(month_ff, leap);
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      rem_in       = rem_ff;
      year_in      = year_ff;
      mod4_in      = mod4_ff;
      mod100_in    = mod100_ff;
      mod400_in    = mod400_ff;
      doy_in       = doy_ff;
      month_in     = month_ff;
      out_valid_in = 1'b0;
      out_item_in  = out_item_ff;
      out_year_in  = out_year_ff;
      out_doy_in   = out_doy_ff;
      out_month_in = out_month_ff;
      out_mday_in  = out_mday_ff;
      queue_pop    = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               item_in   = queue_data;
               rem_in    = queue_data.days;
               year_in   = '0;
               mod4_in   = ecf_pkg::EPOCH_MOD4;
               mod100_in = ecf_pkg::EPOCH_MOD100;
               mod400_in = ecf_pkg::EPOCH_MOD400;
               state_in  = B_YEAR;
            end
         end
         B_YEAR: begin
            // advance one year while the remaining days cover it
            if (rem_ff >= ecf_pkg::DAYS_W'(year_len)) begin
               rem_in    = rem_ff - ecf_pkg::DAYS_W'(year_len);
               year_in   = year_ff + 1'b1;
               mod4_in   = mod4_ff + 1'b1;
               mod100_in = (mod100_ff == ecf_pkg::LAST_MOD100) ? '0 : mod100_ff + 1'b1;
               mod400_in = (mod400_ff == ecf_pkg::LAST_MOD400) ? '0 : mod400_ff + 1'b1;
            end else begin
               doy_in   = rem_ff[8:0];
               month_in = ecf_pkg::MONTH_JAN;
               state_in = B_MONTH;
            end
         end
         B_MONTH: begin
            if ((rem_ff >= ecf_pkg::DAYS_W'(mon_len)) && (month_ff != ecf_pkg::MONTH_DEC)) begin
               rem_in   = rem_ff - ecf_pkg::DAYS_W'(mon_len);
               month_in = month_ff + 1'b1;
            end else begin
               out_valid_in = 1'b1;
               out_item_in  = item_ff;
               out_year_in  = year_ff - ecf_pkg::YEARS_TO_2000;
               out_doy_in   = doy_ff;
               out_month_in = month_ff + 1'b1;
               out_mday_in  = 5'(rem_ff[4:0] + 5'd1);
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff      <= item_in;
      rem_ff       <= rem_in;
      year_ff      <= year_in;
      mod4_ff      <= mod4_in;
      mod100_ff    <= mod100_in;
      mod400_ff    <= mod400_in;
      doy_ff       <= doy_in;
      month_ff     <= month_in;
      out_item_ff  <= out_item_in;
      out_year_ff  <= out_year_in;
      out_doy_ff   <= out_doy_in;
      out_month_ff <= out_month_in;
      out_mday_ff  <= out_mday_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_second_of_minute = out_item_ff.sec;
   assign rsp_minute_of_hour   = out_item_ff.min;
   assign rsp_hour_of_day      = out_item_ff.hour;
   assign rsp_days_since_epoch = out_item_ff.days;
   assign rsp_weekday          = out_item_ff.wday;
   assign rsp_year_from_2000   = $signed(out_year_ff);
   assign rsp_day_in_year      = out_doy_ff;
   assign rsp_month_number     = out_month_ff;
   assign rsp_day_in_month     = out_mday_ff;
   assign rsp_time_valid       = out_item_ff.valid;

endmodule

[hdl/epoch_to_calendar_fields.sv]
`timescale 1ns / 1ps
// A word passes the front end, which divides by 60, 60, 24 and 7 with a multiply state and
// a subtract state each, then the queue, then the back end, which walks the years past 1970
// and then the months past January. The back end walks the years and months while the front
// end converts the next word into a queue of QUEUE_DEPTH entries, two by default.
// Reset (synchronous) empties the queue, idles both ends and loads the threshold
// 1575158400. Results are strobed for one cycle; the receiver cannot stall.
`include "epoch_to_calendar_fields_defines.svh"
module epoch_to_calendar_fields #(
   parameter int QUEUE_DEPTH = ecf_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [31:0]           req_epoch_seconds,
   input  logic                  csr_we,
   input  logic [31:0]           csr_wdata,
   output logic                  rsp_valid,
   output logic [5:0]            rsp_second_of_minute,
   output logic [5:0]            rsp_minute_of_hour,
   output logic [4:0]            rsp_hour_of_day,
   output logic [15:0]           rsp_days_since_epoch,
   output logic [2:0]            rsp_weekday,
   output logic signed [7:0]     rsp_year_from_2000,
   output logic [8:0]            rsp_day_in_year,
   output logic [3:0]            rsp_month_number,
   output logic [4:0]            rsp_day_in_month,
   output logic                  rsp_time_valid
);

   logic [31:0]            valid_after_ff, valid_after_in;
   ecf_pkg::queue_ctl_type qctl;
   ecf_pkg::entry_type     push_data;
   ecf_pkg::entry_type     pop_data;
   logic                   queue_ok;
   logic                   date_ok;
   logic                   time_ok;

   assign valid_after_in = csr_we ? csr_wdata : valid_after_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_after_ff <= ecf_pkg::VALID_AFTER_RESET;
      end else begin
         valid_after_ff <= valid_after_in;
      end
   end

   ecf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .epoch_seconds (req_epoch_seconds),
      .valid_after   (valid_after_ff),
      .queue_full    (qctl.full),
      .queue_push    (qctl.push),
      .queue_data    (push_data)
   );

   ecf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (qctl.push),
      .push_data (push_data),
      .pop       (qctl.pop),
      .pop_data  (pop_data),
      .full      (qctl.full),
      .empty     (qctl.empty)
   );

   ecf_back u_back (
      .clock                (clock),
      .reset                (reset),
      .queue_empty          (qctl.empty),
      .queue_data           (pop_data),
      .queue_pop            (qctl.pop),
      .rsp_valid            (rsp_valid),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_days_since_epoch (rsp_days_since_epoch),
      .rsp_weekday          (rsp_weekday),
      .rsp_year_from_2000   (rsp_year_from_2000),
      .rsp_day_in_year      (rsp_day_in_year),
      .rsp_month_number     (rsp_month_number),
      .rsp_day_in_month     (rsp_day_in_month),
      .rsp_time_valid       (rsp_time_valid)
   );

   assign queue_ok = !(qctl.push && qctl.full) && !(qctl.pop && qctl.empty);
   assign date_ok  = (rsp_month_number >= 4'd1) && (rsp_month_number <= 4'd12)
                     && (rsp_day_in_month >= 5'd1) && (rsp_day_in_year <= 9'd365);
   assign time_ok  = (rsp_hour_of_day <= 5'd23) && (rsp_minute_of_hour <= 6'd59)
                     && (rsp_second_of_minute <= 6'd59) && (rsp_weekday >= 3'd1);

   `ECF_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted word did not raise busy")
   `ECF_ASSERT_NOW(a_queue_sane, clock, reset, 1'b1, queue_ok, "queue overrun or underrun")
   `ECF_ASSERT_NOW(a_date_range, clock, reset, rsp_valid, date_ok, "date field out of range")
   `ECF_ASSERT_NOW(a_time_range, clock, reset, rsp_valid, time_ok, "time field out of range")

endmodule
